@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pss_pkg.sv @@
package pss_pkg;

    localparam int CODE_WIDTH  = 32;
    localparam int TIMER_WIDTH = 16;
    localparam int LEVEL_WIDTH = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LEVEL_WIDTH-1:0] LEARN_LED_LEVEL = 8'd255;
    localparam logic [LEVEL_WIDTH-1:0] RST_ON_BRIGHT   = 8'd255;
    localparam logic [LEVEL_WIDTH-1:0] RST_OFF_BRIGHT  = 8'd0;
    localparam logic [TIMER_WIDTH-1:0] RST_SHUT_TICKS  = 16'd100;
    localparam logic [TIMER_WIDTH-1:0] RST_REBOOT_TICKS = 16'd500;
    localparam logic [TIMER_WIDTH-1:0] RST_LEARN_TICKS = 16'd15000;

    typedef enum logic [2:0] {
        OP_SHORT      = 3'd0,
        OP_LONG       = 3'd1,
        OP_REMOTE     = 3'd2,
        OP_FEEDBACK   = 3'd3,
        OP_LEARN_DONE = 3'd4,
        OP_RECORD     = 3'd5,
        OP_TICK       = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OFF      = 3'd0,
        ST_BOOTING  = 3'd1,
        ST_ON       = 3'd2,
        ST_SHUTDOWN = 3'd3,
        ST_REBOOT   = 3'd4
    } t_power_state;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } t_learn_phase;

    typedef enum logic [2:0] {
        LED_DARK       = 3'd0,
        LED_STEADY     = 3'd1,
        LED_SLOW_FLASH = 3'd2,
        LED_FAST_FLASH = 3'd3,
        LED_COUNT_ONE  = 3'd4,
        LED_COUNT_TWO  = 3'd5
    } t_led_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_BRIGHT    = 3'd0,
        CFG_OFF_BRIGHT   = 3'd1,
        CFG_DARK_MODE    = 3'd2,
        CFG_HOLD_OFF     = 3'd3,
        CFG_SHUT_TICKS   = 3'd4,
        CFG_REBOOT_TICKS = 3'd5,
        CFG_LEARN_TICKS  = 3'd6,
        CFG_SPARE        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]            op;
        logic [CODE_WIDTH-1:0] remote_code;
        logic                  remote_repeat;
        logic [3:0]            pulse_count;
        logic                  feedback_level;
    } t_event;

    typedef struct packed {
        logic                   power_enable;
        logic                   trigger_level;
        logic [2:0]             power_state;
        logic [1:0]             learn_phase;
        logic [2:0]             led_mode;
        logic [LEVEL_WIDTH-1:0] led_level;
        logic                   watch_level;
    } t_result;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] on_brightness;
        logic [LEVEL_WIDTH-1:0] off_brightness;
        logic                   led_dark_mode;
        logic                   hold_forces_off;
        logic [TIMER_WIDTH-1:0] shutdown_trigger_ticks;
        logic [TIMER_WIDTH-1:0] reboot_trigger_ticks;
        logic [TIMER_WIDTH-1:0] learn_timeout_ticks;
    } t_cfg;

    // A programmed length of zero still runs the timer for one tick.
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [TIMER_WIDTH-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        r = (v == '0) ? TIMER_WIDTH'(1) : v;
        return r;
    endfunction

endpackage

@@ rtl/pss_if.sv @@
interface pss_evt_if import pss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            op;
    logic [CODE_WIDTH-1:0] remote_code;
    logic                  remote_repeat;
    logic [3:0]            pulse_count;
    logic                  feedback_level;

    modport source (output valid, op, remote_code, remote_repeat, pulse_count,
                    feedback_level, input ready);
    modport sink (input valid, op, remote_code, remote_repeat, pulse_count,
                  feedback_level, output ready);
endinterface

interface pss_res_if import pss_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   power_enable;
    logic                   trigger_level;
    logic [2:0]             power_state;
    logic [1:0]             learn_phase;
    logic [2:0]             led_mode;
    logic [LEVEL_WIDTH-1:0] led_level;
    logic                   watch_level;

    modport source (output valid, power_enable, trigger_level, power_state, learn_phase,
                    led_mode, led_level, watch_level, input ready);
    modport sink (input valid, power_enable, trigger_level, power_state, learn_phase,
                  led_mode, led_level, watch_level, output ready);
endinterface

interface pss_cfg_if import pss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pss_cfg.sv @@
module pss_cfg import pss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_brightness          <= RST_ON_BRIGHT;
            r_cfg.off_brightness         <= RST_OFF_BRIGHT;
            r_cfg.led_dark_mode          <= 1'b0;
            r_cfg.hold_forces_off        <= 1'b0;
            r_cfg.shutdown_trigger_ticks <= RST_SHUT_TICKS;
            r_cfg.reboot_trigger_ticks   <= RST_REBOOT_TICKS;
            r_cfg.learn_timeout_ticks    <= RST_LEARN_TICKS;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ON_BRIGHT:    r_cfg.on_brightness <= i_cfg.data[LEVEL_WIDTH-1:0];
                CFG_OFF_BRIGHT:   r_cfg.off_brightness <= i_cfg.data[LEVEL_WIDTH-1:0];
                CFG_DARK_MODE:    r_cfg.led_dark_mode <= i_cfg.data[0];
                CFG_HOLD_OFF:     r_cfg.hold_forces_off <= i_cfg.data[0];
                CFG_SHUT_TICKS:   r_cfg.shutdown_trigger_ticks <= i_cfg.data[TIMER_WIDTH-1:0];
                CFG_REBOOT_TICKS: r_cfg.reboot_trigger_ticks <= i_cfg.data[TIMER_WIDTH-1:0];
                CFG_LEARN_TICKS:  r_cfg.learn_timeout_ticks <= i_cfg.data[TIMER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/pss_core.sv @@
module pss_core import pss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_event  i_evt,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_power_state           r_state,      n_state;
    t_learn_phase           r_phase,      n_phase;
    logic                   r_changing,   n_changing;
    logic [CODE_WIDTH-1:0]  r_on_code,    n_on_code;
    logic [CODE_WIDTH-1:0]  r_off_code,   n_off_code;
    logic [LEVEL_WIDTH-1:0] r_led,        n_led;
    logic                   r_trig,       n_trig;
    logic [TIMER_WIDTH-1:0] r_trig_rem,   n_trig_rem;
    logic [TIMER_WIDTH-1:0] r_learn_rem,  n_learn_rem;
    logic                   r_watch,      n_watch;

    // Next state for one event.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_changing  = r_changing;
        n_on_code   = r_on_code;
        n_off_code  = r_off_code;
        n_led       = r_led;
        n_trig      = r_trig;
        n_trig_rem  = r_trig_rem;
        n_learn_rem = r_learn_rem;
        n_watch     = r_watch;

        case (t_op'(i_evt.op))
            OP_SHORT: begin
                case (r_phase)
                    PH_NONE: begin
                        if (r_state == ST_OFF) begin
                            n_state = ST_BOOTING;
                            n_led   = i_cfg.on_brightness;
                            n_watch = 1'b0;
                        end else if (r_state == ST_ON) begin
                            n_learn_rem = '0;
                            n_changing  = 1'b0;
                            n_state     = ST_SHUTDOWN;
                            n_led       = i_cfg.on_brightness;
                            n_watch     = 1'b1;
                            n_trig      = 1'b1;
                            n_trig_rem  = timer_load(i_cfg.shutdown_trigger_ticks);
                        end
                    end
                    PH_ON: begin
                        n_changing  = 1'b1;
                        n_learn_rem = timer_load(i_cfg.learn_timeout_ticks);
                    end
                    PH_OFF: begin
                        n_off_code = r_on_code;
                        n_changing = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_LONG: begin
                if (r_phase == PH_NONE) begin
                    if (r_state == ST_ON) begin
                        if (!i_cfg.hold_forces_off) begin
                            n_learn_rem = '0;
                            n_changing  = 1'b0;
                            n_state     = ST_REBOOT;
                            n_led       = i_cfg.on_brightness;
                            n_watch     = 1'b0;
                            n_trig      = 1'b1;
                            n_trig_rem  = timer_load(i_cfg.reboot_trigger_ticks);
                        end else begin
                            n_state = ST_OFF;
                        end
                    end else if (r_state == ST_OFF) begin
                        n_led       = LEARN_LED_LEVEL;
                        n_phase     = PH_ON;
                        n_changing  = 1'b0;
                        n_learn_rem = timer_load(i_cfg.learn_timeout_ticks);
                    end
                end else begin
                    n_phase     = PH_NONE;
                    n_led       = (r_state == ST_ON) ? i_cfg.on_brightness
                                                     : i_cfg.off_brightness;
                    n_changing  = 1'b0;
                    n_learn_rem = '0;
                end
            end
            OP_REMOTE: begin
                if (!i_evt.remote_repeat) begin
                    case (r_phase)
                        PH_NONE: begin
                            if (i_evt.remote_code == r_on_code && r_state == ST_OFF) begin
                                n_state = ST_BOOTING;
                                n_led   = i_cfg.on_brightness;
                                n_watch = 1'b0;
                            end else if (i_evt.remote_code == r_off_code &&
                                         r_state == ST_ON) begin
                                n_learn_rem = '0;
                                n_changing  = 1'b0;
                                n_state     = ST_SHUTDOWN;
                                n_led       = i_cfg.on_brightness;
                                n_watch     = 1'b1;
                                n_trig      = 1'b1;
                                n_trig_rem  = timer_load(i_cfg.shutdown_trigger_ticks);
                            end
                        end
                        PH_ON: begin
                            n_on_code   = i_evt.remote_code;
                            n_changing  = 1'b1;
                            n_learn_rem = timer_load(i_cfg.learn_timeout_ticks);
                        end
                        PH_OFF: begin
                            n_off_code = i_evt.remote_code;
                            n_changing = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_FEEDBACK: begin
                if (i_evt.pulse_count != 4'd0) begin
                    if (r_state == ST_ON &&
                        (i_evt.pulse_count == 4'd1 || i_evt.pulse_count == 4'd2)) begin
                        // The host has started a change by itself: no trigger pulse.
                        n_phase     = PH_NONE;
                        n_changing  = 1'b0;
                        n_learn_rem = '0;
                        n_led       = i_cfg.on_brightness;
                        if (i_evt.pulse_count == 4'd1) begin
                            n_state = ST_SHUTDOWN;
                            n_watch = 1'b1;
                        end else begin
                            n_state = ST_REBOOT;
                            n_watch = 1'b0;
                        end
                    end
                end else if (!i_evt.feedback_level) begin
                    n_state = ST_ON;
                    n_led   = i_cfg.on_brightness;
                    n_watch = 1'b1;
                end else begin
                    n_state = ST_OFF;
                    n_led   = i_cfg.off_brightness;
                    n_watch = 1'b0;
                end
            end
            OP_LEARN_DONE: begin
                if (r_changing) begin
                    n_changing = 1'b0;
                    if (r_phase == PH_ON) begin
                        n_phase = PH_OFF;
                    end else if (r_phase == PH_OFF) begin
                        n_phase     = PH_NONE;
                        n_led       = (r_state == ST_ON) ? i_cfg.on_brightness
                                                         : i_cfg.off_brightness;
                        n_learn_rem = '0;
                    end
                end
            end
            OP_RECORD: begin
                n_led       = LEARN_LED_LEVEL;
                n_phase     = PH_ON;
                n_changing  = 1'b0;
                n_learn_rem = timer_load(i_cfg.learn_timeout_ticks);
            end
            OP_TICK: begin
                if (r_trig_rem != '0) begin
                    n_trig_rem = r_trig_rem - TIMER_WIDTH'(1);
                    if (r_trig_rem == TIMER_WIDTH'(1)) begin
                        n_trig = 1'b0;
                    end
                end
                if (r_learn_rem != '0) begin
                    n_learn_rem = r_learn_rem - TIMER_WIDTH'(1);
                    if (r_learn_rem == TIMER_WIDTH'(1)) begin
                        n_phase    = PH_NONE;
                        n_led      = (r_state == ST_ON) ? i_cfg.on_brightness
                                                        : i_cfg.off_brightness;
                        n_changing = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result fields, taken from the state after the event.
    always_comb begin
        t_led_mode mode;
        if (n_phase == PH_NONE) begin
            if (i_cfg.led_dark_mode) begin
                mode = LED_DARK;
            end else if (n_state == ST_BOOTING || n_state == ST_SHUTDOWN ||
                         n_state == ST_REBOOT) begin
                mode = LED_SLOW_FLASH;
            end else begin
                mode = LED_STEADY;
            end
        end else if (n_changing) begin
            mode = (n_phase == PH_ON) ? LED_COUNT_ONE : LED_COUNT_TWO;
        end else begin
            mode = LED_FAST_FLASH;
        end
        o_result.power_enable  = (n_state != ST_OFF);
        o_result.trigger_level = n_trig;
        o_result.power_state   = n_state;
        o_result.learn_phase   = n_phase;
        o_result.led_mode      = mode;
        o_result.led_level     = n_led;
        o_result.watch_level   = n_watch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_OFF;
            r_phase     <= PH_NONE;
            r_changing  <= 1'b0;
            r_on_code   <= '0;
            r_off_code  <= '0;
            r_led       <= '0;
            r_trig      <= 1'b0;
            r_trig_rem  <= '0;
            r_learn_rem <= '0;
            r_watch     <= 1'b0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_changing  <= n_changing;
            r_on_code   <= n_on_code;
            r_off_code  <= n_off_code;
            r_led       <= n_led;
            r_trig      <= n_trig;
            r_trig_rem  <= n_trig_rem;
            r_learn_rem <= n_learn_rem;
            r_watch     <= n_watch;
        end
    end

endmodule

@@ rtl/power_switch_sequencer_top.sv @@
// Channel    Direction  Carries
// i_evt      in         one event transaction: op, remote code, repeat, pulse count, level
// o_res      out        one result transaction per event: power, trigger, state, LED
// i_cfg      in         register write transaction: index and data
//
// An event transaction is held in an input register and processed once the result
// register is free or is being emptied; its result is registered in the result
// register and offered from there. One event is accepted every cycle while the
// result channel does not stall; the sustained rate is then one event per cycle.
// i_rst_n is synchronous and active low; it returns all power, learning, timer
// and code state to its cleared values and the registers to their defaults.
// A stalled output holds its result and the input register behind it; the input
// channel stops taking transactions only when both are full.
module power_switch_sequencer_top import pss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pss_evt_if.sink   i_evt,
    pss_res_if.source o_res,
    pss_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_result core_result;

    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    step;
    logic    in_ready;

    // The event in the input register moves on when the result register is free
    // or is being emptied in this cycle.
    assign step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || step;
    assign i_evt.ready = in_ready;

    pss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_evt    (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_evt.valid) begin
            r_in.op             <= i_evt.op;
            r_in.remote_code    <= i_evt.remote_code;
            r_in.remote_repeat  <= i_evt.remote_repeat;
            r_in.pulse_count    <= i_evt.pulse_count;
            r_in.feedback_level <= i_evt.feedback_level;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.power_enable  = r_out.power_enable;
    assign o_res.trigger_level = r_out.trigger_level;
    assign o_res.power_state   = r_out.power_state;
    assign o_res.learn_phase   = r_out.learn_phase;
    assign o_res.led_mode      = r_out.led_mode;
    assign o_res.led_level     = r_out.led_level;
    assign o_res.watch_level   = r_out.watch_level;

endmodule

@@ rtl/pss_checker.sv @@
`include "assert_macros.svh"

module pss_checker import pss_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_power_enable,
    input logic [2:0] i_power_state,
    input logic [1:0] i_learn_phase,
    input logic [2:0] i_led_mode
);

    `ASSERT_IMPLIES(a_enable_matches_state, i_clk, i_rst_n, i_res_valid,
        i_power_enable == (i_power_state != ST_OFF))

    `ASSERT_IMPLIES(a_learning_led_mode, i_clk, i_rst_n,
        i_res_valid && i_learn_phase != PH_NONE,
        i_led_mode == LED_FAST_FLASH || i_led_mode == LED_COUNT_ONE ||
        i_led_mode == LED_COUNT_TWO)

    `ASSERT_IMPLIES(a_count_matches_phase, i_clk, i_rst_n,
        i_res_valid && i_led_mode == LED_COUNT_ONE, i_learn_phase == PH_ON)

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

endmodule

bind power_switch_sequencer_top pss_checker u_pss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_power_enable (o_res.power_enable),
    .i_power_state  (o_res.power_state),
    .i_learn_phase  (o_res.learn_phase),
    .i_led_mode     (o_res.led_mode)
);

@@ bench/tb_power_switch_sequencer_top.sv @@
`timescale 1ns / 1ps

module tb_power_switch_sequencer_top;
    import pss_pkg::*;

    // Length of the single long hold-off on the result channel, in cycles. It is far
    // longer than the two register stages inside the block, so the event channel must
    // stall while the hold lasts.
    localparam int HOLD_CYCLES = 64;
    localparam int DIRECTED_ROWS = 25;

    // One row of the directed table. Where typed is set, want is the result that the
    // row must produce; otherwise the controller mirror supplies the expected status.
    typedef struct {
        t_event  ev;
        bit      typed;
        t_result want;
    } t_row;

    // Register words in index order, spare index last.
    typedef logic [CFG_DATA_W-1:0] t_reg_words [8];

    logic i_clk;
    logic i_rst_n;

    pss_evt_if evt_if ();
    pss_res_if res_if ();
    pss_cfg_if cfg_if ();

    power_switch_sequencer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the controller: power state, learning state, stored codes, LED level,
    // trigger line, both timers and the feedback watch level, plus the registers.
    t_power_state              ctl_state;
    t_learn_phase              ctl_phase;
    logic                      ctl_changing;
    logic [CODE_WIDTH-1:0]     ctl_on_code;
    logic [CODE_WIDTH-1:0]     ctl_off_code;
    logic [LEVEL_WIDTH-1:0]    ctl_led;
    logic                      ctl_trigger;
    logic [TIMER_WIDTH-1:0]    ctl_trigger_left;
    logic [TIMER_WIDTH-1:0]    ctl_learn_left;
    logic                      ctl_watch;
    t_cfg                      reg_mirror;

    // Expected status words, oldest first, one per accepted event transaction.
    t_result pending_status [$];

    // Idling switch shared by both channels, and the count of long hold-offs asked for.
    logic idle_enabled;
    int   hold_requests;

    int mismatch_count;
    int events_sent;
    int results_checked;
    int settings_used;
    int input_stall_cycles;
    int trigger_expiries;
    int learn_timeouts;

    // A 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Safety net: a correct run finishes in a small fraction of this time.
    initial begin
        #2_000_000;
        $display("Timeout: %0d events sent, %0d results compared", events_sent,
                 results_checked);
        $display("power_switch_sequencer_top verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("[%0t] MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                 $realtime, results_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Controller mirror
    // ------------------------------------------------------------------

    // A programmed length of zero still gives one tick.
    function automatic logic [TIMER_WIDTH-1:0] timer_length(input logic [TIMER_WIDTH-1:0] v);
        return (v == '0) ? TIMER_WIDTH'(1) : v;
    endfunction

    function automatic void learning_enter();
        ctl_led        = LEARN_LED_LEVEL;
        ctl_phase      = PH_ON;
        ctl_changing   = 1'b0;
        ctl_learn_left = timer_length(reg_mirror.learn_timeout_ticks);
    endfunction

    // Leaving learning restores the LED level that belongs to the current power state.
    function automatic void learning_leave();
        ctl_phase      = PH_NONE;
        ctl_led        = (ctl_state == ST_ON) ? reg_mirror.on_brightness
                                              : reg_mirror.off_brightness;
        ctl_changing   = 1'b0;
        ctl_learn_left = '0;
    endfunction

    function automatic void enter_booting();
        if (ctl_state != ST_BOOTING) begin
            ctl_state = ST_BOOTING;
            ctl_led   = reg_mirror.on_brightness;
            ctl_watch = 1'b0;
        end
    endfunction

    // Shutdown or reboot. Learning always ends, even when the state does not change.
    function automatic void request_down(input t_power_state target, input bit pulse);
        learning_leave();
        if (ctl_state != target) begin
            ctl_state = target;
            ctl_led   = reg_mirror.on_brightness;
            ctl_watch = (target == ST_SHUTDOWN);
            if (pulse) begin
                ctl_trigger      = 1'b1;
                ctl_trigger_left = timer_length((target == ST_SHUTDOWN)
                                                ? reg_mirror.shutdown_trigger_ticks
                                                : reg_mirror.reboot_trigger_ticks);
            end
        end
    endfunction

    // Applies one event to the mirror and returns the status that the block must report.
    function automatic t_result advance_controller(input t_event ev);
        t_result   st;
        t_led_mode mode;
        case (ev.op)
            OP_SHORT: begin
                if (ctl_phase == PH_NONE) begin
                    if (ctl_state == ST_OFF)
                        enter_booting();
                    else if (ctl_state == ST_ON)
                        request_down(ST_SHUTDOWN, 1'b1);
                end else if (ctl_phase == PH_ON) begin
                    ctl_changing   = 1'b1;
                    ctl_learn_left = timer_length(reg_mirror.learn_timeout_ticks);
                end else if (ctl_phase == PH_OFF) begin
                    // A press while learning the off code reuses the on code.
                    ctl_off_code = ctl_on_code;
                    ctl_changing = 1'b1;
                end
            end
            OP_LONG: begin
                if (ctl_phase == PH_NONE) begin
                    if (ctl_state == ST_ON) begin
                        if (!reg_mirror.hold_forces_off)
                            request_down(ST_REBOOT, 1'b1);
                        else
                            ctl_state = ST_OFF;
                    end else if (ctl_state == ST_OFF) begin
                        learning_enter();
                    end
                end else begin
                    learning_leave();
                end
            end
            OP_REMOTE: begin
                if (!ev.remote_repeat) begin
                    if (ctl_phase == PH_NONE) begin
                        if (ev.remote_code == ctl_on_code && ctl_state == ST_OFF)
                            enter_booting();
                        else if (ev.remote_code == ctl_off_code && ctl_state == ST_ON)
                            request_down(ST_SHUTDOWN, 1'b1);
                    end else if (ctl_phase == PH_ON) begin
                        ctl_on_code    = ev.remote_code;
                        ctl_changing   = 1'b1;
                        ctl_learn_left = timer_length(reg_mirror.learn_timeout_ticks);
                    end else if (ctl_phase == PH_OFF) begin
                        ctl_off_code = ev.remote_code;
                        ctl_changing = 1'b1;
                    end
                end
            end
            OP_FEEDBACK: begin
                if (ev.pulse_count != 4'd0) begin
                    if (ctl_state == ST_ON) begin
                        if (ev.pulse_count == 4'd1)
                            request_down(ST_SHUTDOWN, 1'b0);
                        else if (ev.pulse_count == 4'd2)
                            request_down(ST_REBOOT, 1'b0);
                    end
                end else if (!ev.feedback_level) begin
                    ctl_state = ST_ON;
                    ctl_led   = reg_mirror.on_brightness;
                    ctl_watch = 1'b1;
                end else begin
                    ctl_state = ST_OFF;
                    ctl_led   = reg_mirror.off_brightness;
                    ctl_watch = 1'b0;
                end
            end
            OP_LEARN_DONE: begin
                if (ctl_changing) begin
                    ctl_changing = 1'b0;
                    if (ctl_phase == PH_ON)
                        ctl_phase = PH_OFF;
                    else if (ctl_phase == PH_OFF)
                        learning_leave();
                end
            end
            OP_RECORD: learning_enter();
            OP_TICK: begin
                if (ctl_trigger_left != '0) begin
                    ctl_trigger_left--;
                    if (ctl_trigger_left == '0) begin
                        ctl_trigger = 1'b0;
                        trigger_expiries++;
                    end
                end
                if (ctl_learn_left != '0) begin
                    ctl_learn_left--;
                    if (ctl_learn_left == '0) begin
                        learning_leave();
                        learn_timeouts++;
                    end
                end
            end
            default: ;
        endcase

        if (ctl_phase == PH_NONE) begin
            if (reg_mirror.led_dark_mode)
                mode = LED_DARK;
            else if (ctl_state == ST_BOOTING || ctl_state == ST_SHUTDOWN ||
                     ctl_state == ST_REBOOT)
                mode = LED_SLOW_FLASH;
            else
                mode = LED_STEADY;
        end else if (ctl_changing) begin
            mode = (ctl_phase == PH_ON) ? LED_COUNT_ONE : LED_COUNT_TWO;
        end else begin
            mode = LED_FAST_FLASH;
        end

        st.power_enable  = (ctl_state != ST_OFF);
        st.trigger_level = ctl_trigger;
        st.power_state   = ctl_state;
        st.learn_phase   = ctl_phase;
        st.led_mode      = mode;
        st.led_level     = ctl_led;
        st.watch_level   = ctl_watch;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_event event_of(input t_op op, input logic [CODE_WIDTH-1:0] code,
                                        input bit rep, input logic [3:0] pulses,
                                        input bit level);
        t_event ev;
        ev.op             = op;
        ev.remote_code    = code;
        ev.remote_repeat  = rep;
        ev.pulse_count    = pulses;
        ev.feedback_level = level;
        return ev;
    endfunction

    function automatic t_result status_of(input bit pwr, input bit trig,
                                          input t_power_state st, input t_learn_phase ph,
                                          input t_led_mode mode,
                                          input logic [LEVEL_WIDTH-1:0] led, input bit watch);
        t_result r;
        r.power_enable  = pwr;
        r.trigger_level = trig;
        r.power_state   = st;
        r.learn_phase   = ph;
        r.led_mode      = mode;
        r.led_level     = led;
        r.watch_level   = watch;
        return r;
    endfunction

    // Random events steered by the mirror: remote codes often match a stored code and
    // the feedback level usually completes the transition that is under way, so the
    // power and learning sequences run to their ends. The rest is noise.
    function automatic t_event random_event();
        t_event      ev;
        int unsigned pick;
        pick              = $urandom_range(0, 99);
        ev.remote_code    = $urandom();
        ev.remote_repeat  = ($urandom_range(0, 9) == 0);
        ev.feedback_level = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            ev.pulse_count = 4'($urandom_range(0, 15));
        else if ($urandom_range(0, 1) == 0)
            ev.pulse_count = 4'd0;
        else
            ev.pulse_count = 4'($urandom_range(1, 2));
        if ($urandom_range(0, 4) != 0) begin
            if (ctl_state == ST_BOOTING)
                ev.feedback_level = 1'b0;
            else if (ctl_state == ST_SHUTDOWN || ctl_state == ST_REBOOT)
                ev.feedback_level = 1'b1;
        end

        if (pick < 14) begin
            ev.op = OP_SHORT;
        end else if (pick < 22) begin
            ev.op = OP_LONG;
        end else if (pick < 38) begin
            ev.op = OP_REMOTE;
            if ($urandom_range(0, 2) != 0)
                ev.remote_code = $urandom_range(0, 1) ? ctl_on_code : ctl_off_code;
        end else if (pick < 54) begin
            ev.op = OP_FEEDBACK;
        end else if (pick < 66) begin
            ev.op = OP_LEARN_DONE;
        end else if (pick < 71) begin
            ev.op = OP_RECORD;
        end else if (pick < 96) begin
            ev.op = OP_TICK;
        end else begin
            ev.op = OP_NONE;
        end
        return ev;
    endfunction

    // Register words for a random setting. The brightness and flag words carry random
    // upper bits, which the block must ignore; the timers are kept short so that the
    // trigger pulse and the learning watchdog expire often.
    function automatic t_reg_words random_regs(input int max_ticks);
        t_reg_words w;
        w[CFG_ON_BRIGHT]    = CFG_DATA_W'($urandom_range(0, 65535));
        w[CFG_OFF_BRIGHT]   = CFG_DATA_W'($urandom_range(0, 65535));
        w[CFG_DARK_MODE]    = CFG_DATA_W'($urandom_range(0, 65535));
        w[CFG_HOLD_OFF]     = CFG_DATA_W'($urandom_range(0, 65535));
        w[CFG_SHUT_TICKS]   = CFG_DATA_W'($urandom_range(1, max_ticks));
        w[CFG_REBOOT_TICKS] = CFG_DATA_W'($urandom_range(1, max_ticks));
        w[CFG_LEARN_TICKS]  = CFG_DATA_W'($urandom_range(2, 2 * max_ticks));
        w[CFG_SPARE]        = CFG_DATA_W'($urandom_range(0, 65535));
        return w;
    endfunction

    // Offers one event transaction and waits for it to be taken. The ready line is
    // looked at on the falling edge, where it has settled, so the transaction is taken
    // at the rising edge that follows a high ready. The valid line stays high from one
    // event to the next unless a gap is inserted, so it never sees two assignments in
    // the same time step.
    task automatic send_event(input t_event ev, input bit typed, input t_result want);
        t_result predicted;
        if (idle_enabled && $urandom_range(0, 4) == 0) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        evt_if.valid          <= 1'b1;
        evt_if.op             <= ev.op;
        evt_if.remote_code    <= ev.remote_code;
        evt_if.remote_repeat  <= ev.remote_repeat;
        evt_if.pulse_count    <= ev.pulse_count;
        evt_if.feedback_level <= ev.feedback_level;
        @(negedge i_clk);
        while (!evt_if.ready) begin
            input_stall_cycles++;
            @(negedge i_clk);
        end
        @(posedge i_clk);
        predicted = advance_controller(ev);
        pending_status.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(negedge i_clk);
        while (!cfg_if.ready)
            @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            CFG_ON_BRIGHT:    reg_mirror.on_brightness          = value[LEVEL_WIDTH-1:0];
            CFG_OFF_BRIGHT:   reg_mirror.off_brightness         = value[LEVEL_WIDTH-1:0];
            CFG_DARK_MODE:    reg_mirror.led_dark_mode          = value[0];
            CFG_HOLD_OFF:     reg_mirror.hold_forces_off        = value[0];
            CFG_SHUT_TICKS:   reg_mirror.shutdown_trigger_ticks = value[TIMER_WIDTH-1:0];
            CFG_REBOOT_TICKS: reg_mirror.reboot_trigger_ticks   = value[TIMER_WIDTH-1:0];
            CFG_LEARN_TICKS:  reg_mirror.learn_timeout_ticks    = value[TIMER_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Waits until every expected result has come back or the limit is reached, then lets the pipeline settle.
    task automatic drain(input int limit);
        int waited;
        waited = 0;
        while (pending_status.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One phase of the run: the block is drained, every register is rewritten, and a
    // batch of random events follows. One phase asks for the long hold-off half way.
    task automatic run_phase(input t_reg_words regs, input int n_events, input bit idle,
                             input bit with_hold);
        drain(20000);
        idle_enabled <= idle;
        for (int i = 0; i < 8; i++)
            write_reg(t_cfg_idx'(i), regs[i]);
        cfg_if.valid <= 1'b0;
        settings_used++;
        for (int n = 0; n < n_events; n++) begin
            if (with_hold && n == n_events / 2)
                hold_requests <= hold_requests + 1;
            send_event(random_event(), 1'b0, '0);
        end
        evt_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls in bursts while idling is enabled, the long hold-off
    // on request, and the comparison of each result transaction with the oldest expected
    // status. The handshake and the payload are sampled on the falling edge, where they
    // have settled, and the transaction counts at the rising edge that follows.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int      stall_left;
        int      hold_left;
        int      holds_served;
        bit      took;
        t_result got;
        t_result want;
        stall_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            took              = (i_rst_n === 1'b1) && (res_if.valid === 1'b1) &&
                                (res_if.ready === 1'b1);
            got.power_enable  = res_if.power_enable;
            got.trigger_level = res_if.trigger_level;
            got.power_state   = res_if.power_state;
            got.learn_phase   = res_if.learn_phase;
            got.led_mode      = res_if.led_mode;
            got.led_level     = res_if.led_level;
            got.watch_level   = res_if.watch_level;
            @(posedge i_clk);
            if (took) begin
                if (pending_status.size() == 0) begin
                    report_mismatch("result with nothing pending", got, 0);
                end else begin
                    want = pending_status.pop_front();
                    if (got.power_enable !== want.power_enable)
                        report_mismatch("power_enable", got.power_enable, want.power_enable);
                    if (got.trigger_level !== want.trigger_level)
                        report_mismatch("trigger_level", got.trigger_level,
                                        want.trigger_level);
                    if (got.power_state !== want.power_state)
                        report_mismatch("power_state", got.power_state, want.power_state);
                    if (got.learn_phase !== want.learn_phase)
                        report_mismatch("learn_phase", got.learn_phase, want.learn_phase);
                    if (got.led_mode !== want.led_mode)
                        report_mismatch("led_mode", got.led_mode, want.led_mode);
                    if (got.led_level !== want.led_level)
                        report_mismatch("led_level", got.led_level, want.led_level);
                    if (got.watch_level !== want.watch_level)
                        report_mismatch("watch_level", got.watch_level, want.watch_level);
                end
                results_checked++;
            end

            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
                stall_left   = int'($urandom_range(1, 12)) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row       rows [DIRECTED_ROWS];
        t_reg_words regs;

        // Every input of the block is known from time zero, while reset is held low.
        i_rst_n               <= 1'b0;
        evt_if.valid          <= 1'b0;
        evt_if.op             <= OP_NONE;
        evt_if.remote_code    <= '0;
        evt_if.remote_repeat  <= 1'b0;
        evt_if.pulse_count    <= '0;
        evt_if.feedback_level <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= CFG_ON_BRIGHT;
        cfg_if.data           <= '0;
        idle_enabled          <= 1'b1;
        hold_requests         <= 0;

        mismatch_count     = 0;
        events_sent        = 0;
        results_checked    = 0;
        settings_used      = 0;
        input_stall_cycles = 0;
        trigger_expiries   = 0;
        learn_timeouts     = 0;

        // The mirror starts from the cleared state with the default registers.
        ctl_state        = ST_OFF;
        ctl_phase        = PH_NONE;
        ctl_changing     = 1'b0;
        ctl_on_code      = '0;
        ctl_off_code     = '0;
        ctl_led          = '0;
        ctl_trigger      = 1'b0;
        ctl_trigger_left = '0;
        ctl_learn_left   = '0;
        ctl_watch        = 1'b0;
        reg_mirror.on_brightness          = RST_ON_BRIGHT;
        reg_mirror.off_brightness         = RST_OFF_BRIGHT;
        reg_mirror.led_dark_mode          = 1'b0;
        reg_mirror.hold_forces_off        = 1'b0;
        reg_mirror.shutdown_trigger_ticks = RST_SHUT_TICKS;
        reg_mirror.reboot_trigger_ticks   = RST_REBOOT_TICKS;
        reg_mirror.learn_timeout_ticks    = RST_LEARN_TICKS;

        // Directed walk under the default registers. The first rows must leave the
        // cleared state untouched: the unused operation, a repeat frame that carries
        // the (still zero) on code, a stray learn-done and a pulse report while off.
        rows[0]  = '{event_of(OP_NONE, '0, 1'b0, 4'd0, 1'b0), 1'b1,
                     status_of(1'b0, 1'b0, ST_OFF, PH_NONE, LED_STEADY, 8'd0, 1'b0)};
        rows[1]  = '{event_of(OP_REMOTE, '0, 1'b1, 4'd0, 1'b0), 1'b1,
                     status_of(1'b0, 1'b0, ST_OFF, PH_NONE, LED_STEADY, 8'd0, 1'b0)};
        rows[2]  = '{event_of(OP_LEARN_DONE, '0, 1'b0, 4'd0, 1'b0), 1'b1,
                     status_of(1'b0, 1'b0, ST_OFF, PH_NONE, LED_STEADY, 8'd0, 1'b0)};
        rows[3]  = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd1, 1'b1), 1'b1,
                     status_of(1'b0, 1'b0, ST_OFF, PH_NONE, LED_STEADY, 8'd0, 1'b0)};
        // Power up through booting to on, then the on-state pulse counts that do nothing.
        rows[4]  = '{event_of(OP_SHORT, '0, 1'b0, 4'd0, 1'b0), 1'b1,
                     status_of(1'b1, 1'b0, ST_BOOTING, PH_NONE, LED_SLOW_FLASH, 8'd255, 1'b0)};
        rows[5]  = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd0, 1'b0), 1'b1,
                     status_of(1'b1, 1'b0, ST_ON, PH_NONE, LED_STEADY, 8'd255, 1'b1)};
        rows[6]  = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd3, 1'b0), 1'b0, '0};
        rows[7]  = '{event_of(OP_FEEDBACK, '1, 1'b1, 4'd15, 1'b1), 1'b0, '0};
        // Short press asks for a shutdown and raises the trigger line.
        rows[8]  = '{event_of(OP_SHORT, '0, 1'b0, 4'd0, 1'b0), 1'b1,
                     status_of(1'b1, 1'b1, ST_SHUTDOWN, PH_NONE, LED_SLOW_FLASH, 8'd255, 1'b1)};
        rows[9]  = '{event_of(OP_TICK, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[10] = '{event_of(OP_SHORT, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[11] = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd0, 1'b1), 1'b0, '0};
        // Learn an all-ones on code, then copy it to the off code with a press.
        rows[12] = '{event_of(OP_LONG, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[13] = '{event_of(OP_REMOTE, '1, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[14] = '{event_of(OP_LEARN_DONE, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[15] = '{event_of(OP_SHORT, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[16] = '{event_of(OP_LEARN_DONE, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        // The learned code powers the host up; two pulses report a reboot.
        rows[17] = '{event_of(OP_REMOTE, '1, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[18] = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[19] = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd2, 1'b0), 1'b0, '0};
        rows[20] = '{event_of(OP_FEEDBACK, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        // Long press while on asks for a reboot; a record command then starts learning
        // in the reboot state and a long press ends it.
        rows[21] = '{event_of(OP_LONG, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[22] = '{event_of(OP_RECORD, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[23] = '{event_of(OP_LONG, '0, 1'b0, 4'd0, 1'b0), 1'b0, '0};
        rows[24] = '{event_of(OP_NONE, '1, 1'b1, 4'd15, 1'b1), 1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_event(rows[i].ev, rows[i].typed, rows[i].want);
        evt_if.valid <= 1'b0;

        // Defaults written back explicitly.
        regs[CFG_ON_BRIGHT]    = 16'(RST_ON_BRIGHT);
        regs[CFG_OFF_BRIGHT]   = 16'(RST_OFF_BRIGHT);
        regs[CFG_DARK_MODE]    = 16'd0;
        regs[CFG_HOLD_OFF]     = 16'd0;
        regs[CFG_SHUT_TICKS]   = 16'(RST_SHUT_TICKS);
        regs[CFG_REBOOT_TICKS] = 16'(RST_REBOOT_TICKS);
        regs[CFG_LEARN_TICKS]  = 16'(RST_LEARN_TICKS);
        regs[CFG_SPARE]        = 16'd0;
        run_phase(regs, 120, 1'b1, 1'b0);

        // Every register at zero but the hold flag: each timer length of zero must still run for one tick,
        // and a long press while on cuts the power outright.
        regs = '{default: 16'd0};
        regs[CFG_HOLD_OFF] = 16'd1;
        run_phase(regs, 150, 1'b1, 1'b0);

        // Every register at its largest value, dark LED, forced power cut.
        regs = '{default: 16'hFFFF};
        run_phase(regs, 120, 1'b1, 1'b0);

        // Short timers; the result channel is held off once for a long stretch here.
        run_phase(random_regs(8), 180, 1'b1, 1'b1);
        run_phase(random_regs(30), 180, 1'b1, 1'b0);

        // The last stretch runs at full rate on both channels.
        run_phase(random_regs(12), 150, 1'b0, 1'b0);

        drain(20000);
        if (pending_status.size() != 0)
            report_mismatch("results never returned", pending_status.size(), 0);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d events (%0d directed) over %0d register settings, %0d results",
                 events_sent, DIRECTED_ROWS, settings_used, results_checked);
        $display("Saw %0d stalled event cycles, %0d trigger expiries, %0d learning timeouts",
                 input_stall_cycles, trigger_expiries, learn_timeouts);
        if (mismatch_count == 0) begin
            $display("power_switch_sequencer_top verification clean");
        end else begin
            $display("power_switch_sequencer_top verification failed");
        end
        $finish;
    end

endmodule
